FILE: src/tli_pkg.sv
// shared types, constants and codes of the tape language interpreter
`timescale 1ns / 1ps

package tli_pkg;

  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned TAPE_DEPTH = 32768;
  localparam int unsigned RUN_LIMIT  = 1048576;

  localparam int unsigned PA_W  = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W  = PA_W + 1;
  localparam int unsigned TA_W  = $clog2(TAPE_DEPTH);
  localparam int unsigned TS_W  = TA_W + 1;
  localparam int unsigned CNT_W = $clog2(RUN_LIMIT) + 1;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_SUPPLY = 2'd2,
    FUNC_RESUME = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STAT_LOADED   = 3'd0,
    STAT_OUTPUT   = 3'd1,
    STAT_AWAIT    = 3'd2,
    STAT_HALTED   = 3'd3,
    STAT_OVERFLOW = 3'd4,
    STAT_BADCHAR  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_SF_ISSUE,
    S_SF_CHECK,
    S_SB_ISSUE,
    S_SB_CHECK
  } state_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
  } result_t;

  typedef struct packed {
    logic            we;
    logic [PA_W-1:0] addr;
    logic [7:0]      wdata;
  } prog_req_t;

  typedef struct packed {
    logic            we;
    logic [TA_W-1:0] addr;
    logic [7:0]      wdata;
  } tape_req_t;

endpackage

FILE: src/tli_ram.sv
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps

module tli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tli_ctrl.sv
// interpreter sequencer: load, fetch, execute, bracket scans and tape extent
`timescale 1ns / 1ps

module tli_ctrl import tli_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  item_t     item_i,
  output result_t   result_o,
  output logic      done_o,
  output prog_req_t prog_req_o,
  input  logic [7:0] prog_rdata_i,
  output tape_req_t tape_req_o,
  input  logic [7:0] tape_rdata_i
);

  state_e           state_q, state_d;
  logic [PC_W-1:0]  len_q, len_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [PC_W-1:0]  j_q, j_d;
  logic [PC_W-1:0]  depth_q, depth_d;
  logic [TA_W-1:0]  tp_q, tp_d;
  logic [TA_W-1:0]  hi_q, hi_d;
  logic [TA_W-1:0]  lo_q, lo_d;
  logic [TS_W-1:0]  size_q, size_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             await_q, await_d;
  logic             done_q, done_d;
  result_t          res_q, res_d;

  logic [TA_W-1:0]  tp_inc, tp_dec;
  logic             full;
  logic             limit;
  state_e           after_cmd;
  logic [7:0]       c;

  assign tp_inc    = (tp_q == TA_W'(TAPE_DEPTH - 1)) ? '0 : tp_q + TA_W'(1);
  assign tp_dec    = (tp_q == '0) ? TA_W'(TAPE_DEPTH - 1) : tp_q - TA_W'(1);
  assign full      = (size_q == TS_W'(TAPE_DEPTH));
  assign c         = prog_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      len_q   <= '0;
      pc_q    <= '0;
      j_q     <= '0;
      depth_q <= '0;
      tp_q    <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      size_q  <= TS_W'(1);
      cnt_q   <= '0;
      await_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pc_q    <= pc_d;
      j_q     <= j_d;
      depth_q <= depth_d;
      tp_q    <= tp_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
      await_q <= await_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    pc_d       = pc_q;
    j_d        = j_q;
    depth_d    = depth_q;
    tp_d       = tp_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    size_d     = size_q;
    cnt_d      = cnt_q;
    await_d    = await_q;
    done_d     = 1'b0;
    res_d      = res_q;
    prog_req_o = '{we: 1'b0, addr: pc_q[PA_W-1:0], wdata: item_i.data_byte};
    tape_req_o = '{we: 1'b0, addr: tp_q, wdata: '0};

    if (state_q == S_EXEC) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    limit     = (cnt_d == CNT_W'(RUN_LIMIT));
    after_cmd = limit ? S_IDLE : S_FETCH;

    unique case (state_q)
      S_INIT: begin
        tape_req_o.we   = 1'b1;
        tape_req_o.addr = '0;
        state_d         = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cnt_d = '0;
          unique case (item_i.func)
            FUNC_LOAD: begin
              done_d = 1'b1;
              res_d  = '{status: STAT_LOADED, out_byte: '0};
              if (item_i.data_byte == CH_LF || item_i.data_byte == CH_CR) begin
                res_d.status = STAT_LOADED;
              end else if (len_q >= PC_W'(PROG_DEPTH)) begin
                res_d.status = STAT_OVERFLOW;
              end else begin
                prog_req_o.we   = 1'b1;
                prog_req_o.addr = len_q[PA_W-1:0];
                len_d           = len_q + PC_W'(1);
              end
            end
            FUNC_START: begin
              tape_req_o.we   = 1'b1;
              tape_req_o.addr = '0;
              tp_d    = '0;
              pc_d    = '0;
              depth_d = '0;
              await_d = 1'b0;
              hi_d    = '0;
              lo_d    = '0;
              size_d  = TS_W'(1);
              state_d = S_FETCH;
            end
            FUNC_SUPPLY: begin
              if (await_q) begin
                tape_req_o.we    = 1'b1;
                tape_req_o.wdata = item_i.data_byte;
                await_d          = 1'b0;
                pc_d             = pc_q + PC_W'(1);
              end
              state_d = S_FETCH;
            end
            FUNC_RESUME: begin
              if (await_q) begin
                done_d = 1'b1;
                res_d  = '{status: STAT_AWAIT, out_byte: '0};
              end else begin
                state_d = S_FETCH;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FETCH: begin
        if (pc_q >= len_q) begin
          done_d  = 1'b1;
          res_d   = '{status: STAT_HALTED, out_byte: '0};
          state_d = S_IDLE;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = after_cmd;
        unique case (c)
          CH_GT: begin
            if (!full && tp_q == hi_q) begin
              tape_req_o.we   = 1'b1;
              tape_req_o.addr = tp_inc;
              hi_d            = tp_inc;
              size_d          = size_q + TS_W'(1);
            end
            tp_d = tp_inc;
            pc_d = pc_q + PC_W'(1);
          end
          CH_LT: begin
            if (!full && tp_q == lo_q) begin
              tape_req_o.we   = 1'b1;
              tape_req_o.addr = tp_dec;
              lo_d            = tp_dec;
              size_d          = size_q + TS_W'(1);
            end
            tp_d = tp_dec;
            pc_d = pc_q + PC_W'(1);
          end
          CH_PLUS: begin
            tape_req_o.we    = 1'b1;
            tape_req_o.wdata = tape_rdata_i + 8'd1;
            pc_d             = pc_q + PC_W'(1);
          end
          CH_MINUS: begin
            tape_req_o.we    = 1'b1;
            tape_req_o.wdata = tape_rdata_i - 8'd1;
            pc_d             = pc_q + PC_W'(1);
          end
          CH_DOT: begin
            pc_d    = pc_q + PC_W'(1);
            done_d  = 1'b1;
            res_d   = '{status: STAT_OUTPUT, out_byte: tape_rdata_i};
            state_d = S_IDLE;
          end
          CH_COMMA: begin
            await_d = 1'b1;
            done_d  = 1'b1;
            res_d   = '{status: STAT_AWAIT, out_byte: '0};
            state_d = S_IDLE;
          end
          CH_LBR: begin
            if (tape_rdata_i == 8'd0) begin
              depth_d = PC_W'(1);
              j_d     = pc_q + PC_W'(1);
              state_d = S_SF_ISSUE;
            end else begin
              pc_d = pc_q + PC_W'(1);
            end
          end
          CH_RBR: begin
            if (tape_rdata_i != 8'd0) begin
              depth_d = PC_W'(1);
              j_d     = pc_q;
              state_d = S_SB_ISSUE;
            end else begin
              pc_d = pc_q + PC_W'(1);
            end
          end
          CH_NUL: begin
            done_d  = 1'b1;
            res_d   = '{status: STAT_HALTED, out_byte: '0};
            state_d = S_IDLE;
          end
          default: begin
            pc_d    = pc_q + PC_W'(1);
            done_d  = 1'b1;
            res_d   = '{status: STAT_BADCHAR, out_byte: c};
            state_d = S_IDLE;
          end
        endcase
      end
      S_SF_ISSUE: begin
        if (j_q >= len_q) begin
          depth_d = '0;
          pc_d    = len_q;
          state_d = after_cmd;
        end else begin
          prog_req_o.addr = j_q[PA_W-1:0];
          state_d         = S_SF_CHECK;
        end
      end
      S_SF_CHECK: begin
        state_d = S_SF_ISSUE;
        j_d     = j_q + PC_W'(1);
        if (c == CH_LBR) begin
          depth_d = depth_q + PC_W'(1);
        end else if (c == CH_RBR) begin
          depth_d = depth_q - PC_W'(1);
          if (depth_q == PC_W'(1)) begin
            pc_d    = j_q + PC_W'(1);
            state_d = after_cmd;
          end
        end
      end
      S_SB_ISSUE: begin
        if (j_q == '0) begin
          depth_d = '0;
          pc_d    = pc_q + PC_W'(1);
          state_d = after_cmd;
        end else begin
          j_d             = j_q - PC_W'(1);
          prog_req_o.addr = j_d[PA_W-1:0];
          state_d         = S_SB_CHECK;
        end
      end
      S_SB_CHECK: begin
        state_d = S_SB_ISSUE;
        if (c == CH_RBR) begin
          depth_d = depth_q + PC_W'(1);
        end else if (c == CH_LBR) begin
          depth_d = depth_q - PC_W'(1);
          if (depth_q == PC_W'(1)) begin
            pc_d    = j_q + PC_W'(1);
            state_d = after_cmd;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: src/tape_language_interpreter_core.sv
// top level: program store, tape store and the interpreter sequencer
// a load or a resume while awaiting input gives its result one cycle after acceptance
// a run takes two cycles per plain command and two cycles per program entry scanned
//   by a bracket search; start, supply and resume add one cycle, busy stays high until the event
// a run with no event for 1048576 commands ends without a result; resume continues it
// after reset one cycle writes tape cell zero; the tape is never swept, a visited-extent
//   tracker zeroes each cell on its first visit; results cannot be stalled
`timescale 1ns / 1ps

module tape_language_interpreter_core import tli_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    done_o
);

  prog_req_t  prog_req;
  tape_req_t  tape_req;
  logic [7:0] prog_rdata;
  logic [7:0] tape_rdata;

  tli_ram #(
    .WIDTH (8),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_req.we),
    .addr_i  (prog_req.addr),
    .wdata_i (prog_req.wdata),
    .rdata_o (prog_rdata)
  );

  tli_ram #(
    .WIDTH (8),
    .DEPTH (TAPE_DEPTH)
  ) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_req.we),
    .addr_i  (tape_req.addr),
    .wdata_i (tape_req.wdata),
    .rdata_o (tape_rdata)
  );

  tli_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .result_o     (result_o),
    .done_o       (done_o),
    .prog_req_o   (prog_req),
    .prog_rdata_i (prog_rdata),
    .tape_req_o   (tape_req),
    .tape_rdata_i (tape_rdata)
  );

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the tape language interpreter core
`timescale 1ns / 1ps

module tb_top;
  import tli_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_ITEMS = 1600;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   cmd_item = '0;
  result_t result;
  logic    result_valid;

  // interpreter image kept by the testbench
  logic [7:0]  prog_img [PROG_DEPTH];
  logic [7:0]  tape_img [TAPE_DEPTH];
  int unsigned prog_len;
  int unsigned head_pos;
  int unsigned instr_pc;
  int unsigned bracket_depth;
  bit          want_input;

  result_t     pending_events [$];
  status_e     last_status;
  bit          last_had_event;
  bit          idle_on = 1'b1;
  int unsigned items_sent;
  int unsigned cycles;
  int          err_count;

  tape_language_interpreter_core i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start    (start),
    .busy     (busy),
    .item_i   (cmd_item),
    .result_o (result),
    .done_o   (result_valid)
  );

  always #6 clk = ~clk;

  function automatic void seek_close();
    int unsigned j;
    bracket_depth = 1;
    for (j = instr_pc + 1; j < prog_len; j++) begin
      if (prog_img[j] == CH_LBR) begin
        bracket_depth++;
      end else if (prog_img[j] == CH_RBR) begin
        bracket_depth--;
        if (bracket_depth == 0) begin
          instr_pc = j + 1;
          return;
        end
      end
    end
    bracket_depth = 0;
    instr_pc = prog_len;
  endfunction

  function automatic void seek_open();
    int unsigned j;
    j = instr_pc;
    bracket_depth = 1;
    while (j > 0) begin
      j--;
      if (prog_img[j] == CH_RBR) begin
        bracket_depth++;
      end else if (prog_img[j] == CH_LBR) begin
        bracket_depth--;
        if (bracket_depth == 0) begin
          instr_pc = j + 1;
          return;
        end
      end
    end
    bracket_depth = 0;
    instr_pc++;
  endfunction

  function automatic bit run_to_event(output result_t ev);
    int unsigned budget;
    int unsigned tp;
    logic [7:0]  c;
    budget = RUN_LIMIT;
    ev.status = STAT_HALTED;
    ev.out_byte = 8'h00;
    while (budget > 0) begin
      tp = head_pos % TAPE_DEPTH;
      if (instr_pc >= prog_len || instr_pc >= PROG_DEPTH) begin
        ev.status = STAT_HALTED;
        return 1'b1;
      end
      c = prog_img[instr_pc];
      budget--;
      case (c)
        CH_GT: begin
          head_pos = (tp + 1) % TAPE_DEPTH;
          instr_pc++;
        end
        CH_LT: begin
          head_pos = (tp + TAPE_DEPTH - 1) % TAPE_DEPTH;
          instr_pc++;
        end
        CH_PLUS: begin
          tape_img[tp] = tape_img[tp] + 8'd1;
          instr_pc++;
        end
        CH_MINUS: begin
          tape_img[tp] = tape_img[tp] - 8'd1;
          instr_pc++;
        end
        CH_DOT: begin
          instr_pc++;
          ev.status = STAT_OUTPUT;
          ev.out_byte = tape_img[tp];
          return 1'b1;
        end
        CH_COMMA: begin
          want_input = 1'b1;
          ev.status = STAT_AWAIT;
          return 1'b1;
        end
        CH_LBR: begin
          if (tape_img[tp] == 8'h00) seek_close();
          else instr_pc++;
        end
        CH_RBR: begin
          if (tape_img[tp] != 8'h00) seek_open();
          else instr_pc++;
        end
        CH_NUL: begin
          ev.status = STAT_HALTED;
          return 1'b1;
        end
        default: begin
          instr_pc++;
          ev.status = STAT_BADCHAR;
          ev.out_byte = c;
          return 1'b1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic bit interpret_item(input item_t it, output result_t ev);
    int unsigned i;
    ev.status = STAT_LOADED;
    ev.out_byte = 8'h00;
    case (it.func)
      FUNC_LOAD: begin
        if (it.data_byte == CH_LF || it.data_byte == CH_CR) begin
          ev.status = STAT_LOADED;
        end else if (prog_len >= PROG_DEPTH) begin
          ev.status = STAT_OVERFLOW;
        end else begin
          prog_img[prog_len] = it.data_byte;
          prog_len++;
        end
        return 1'b1;
      end
      FUNC_START: begin
        for (i = 0; i < TAPE_DEPTH; i++) tape_img[i] = 8'h00;
        head_pos = 0;
        instr_pc = 0;
        bracket_depth = 0;
        want_input = 1'b0;
        return run_to_event(ev);
      end
      FUNC_SUPPLY: begin
        if (want_input) begin
          tape_img[head_pos % TAPE_DEPTH] = it.data_byte;
          want_input = 1'b0;
          instr_pc++;
        end
        return run_to_event(ev);
      end
      default: begin
        if (want_input) begin
          ev.status = STAT_AWAIT;
          return 1'b1;
        end
        return run_to_event(ev);
      end
    endcase
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_GT || c == CH_LT || c == CH_PLUS || c == CH_MINUS || c == CH_DOT ||
           c == CH_COMMA || c == CH_LBR || c == CH_RBR || c == CH_NUL || c == CH_LF ||
           c == CH_CR) begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // no brackets and no zero, so loops stay bounded
  function automatic logic [7:0] plain_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 18) return CH_PLUS;
    if (r < 30) return CH_MINUS;
    if (r < 44) return CH_GT;
    if (r < 54) return CH_LT;
    if (r < 68) return CH_DOT;
    if (r < 78) return CH_COMMA;
    if (r < 86) return r[0] ? CH_LF : CH_CR;
    return bad_char();
  endfunction

  function automatic logic [7:0] supply_byte();
    if ($urandom_range(99) < 70) return 8'($urandom_range(4));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input func_e f, input logic [7:0] b);
    item_t   it;
    result_t ev;
    bit      taken;
    it.func = f;
    it.data_byte = b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (idle_on && $urandom_range(99) < 16) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        cmd_item <= it;
      end
      @(posedge clk);
      if (start && !busy) taken = 1'b1;
    end
    last_had_event = interpret_item(it, ev);
    last_status = ev.status;
    if (last_had_event) pending_events.push_back(ev);
    items_sent++;
  endtask

  task automatic load_char(input logic [7:0] c);
    send_item(FUNC_LOAD, c);
  endtask

  task automatic load_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) load_char(s[i]);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic drive_to_halt(input int cap);
    int          k;
    int unsigned r;
    k = 0;
    while (k < cap && !(last_had_event && last_status == STAT_HALTED)) begin
      r = $urandom_range(9);
      if (want_input) begin
        if (r == 0) send_item(FUNC_RESUME, 8'($urandom_range(255)));
        else if (r == 1) load_char(plain_char());
        else send_item(FUNC_SUPPLY, supply_byte());
      end else begin
        if (r == 0) send_item(FUNC_SUPPLY, 8'($urandom_range(255)));
        else if (r == 1) load_char(plain_char());
        else send_item(FUNC_RESUME, 8'($urandom_range(255)));
      end
      k++;
    end
  endtask

  // loop bodies count their own cell down and work one cell to the right
  task automatic load_snippet();
    int          n;
    int          m;
    int unsigned t;
    n = $urandom_range(8, 1);
    repeat (n) begin
      t = $urandom_range(99);
      if (t < 2) begin
        load_char(CH_LBR);
      end else if (t < 16) begin
        load_char(CH_LBR);
        load_char(CH_MINUS);
        load_char(CH_GT);
        m = $urandom_range(4);
        repeat (m) begin
          case ($urandom_range(5))
            0: load_char(CH_PLUS);
            1: load_char(CH_MINUS);
            2: load_char(CH_DOT);
            3: load_char(CH_COMMA);
            4: load_char(CH_LF);
            default: load_char(bad_char());
          endcase
        end
        load_char(CH_LT);
        load_char(CH_RBR);
      end else begin
        load_char(plain_char());
      end
    end
  endtask

  task automatic test_before_start();
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_SUPPLY, 8'hA5);
    send_item(FUNC_START, 8'hFF);
    wait_drain();
  endtask

  task automatic test_directed_program();
    load_text("+]-]<++.>.-.+,");
    load_char(CH_LF);
    load_char(CH_CR);
    load_char(8'h41);
    load_char(8'hFF);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_RESUME, 8'hFF);
    load_text(">+++[->++[->+.<]<][.]");
    send_item(FUNC_SUPPLY, 8'h80);
    send_item(FUNC_RESUME, 8'h00);
    drive_to_halt(60);
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_SUPPLY, 8'h5A);
    wait_drain();
  endtask

  task automatic test_restart_clears_tape();
    send_item(FUNC_START, 8'h00);
    drive_to_halt(80);
    wait_drain();
  endtask

  task automatic test_random_sessions();
    int unsigned first;
    int unsigned r;
    int          n;
    bit          drained;
    first = items_sent;
    drained = 1'b0;
    while (items_sent - first < RANDOM_ITEMS) begin
      idle_on = !((items_sent - first) > 400 && (items_sent - first) < 700);
      if (!drained && (items_sent - first) > 800) begin
        wait_drain();
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 4) begin
        send_item(FUNC_START, 8'($urandom_range(255)));
        drive_to_halt(600);
      end else if (r < 12) begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          case ($urandom_range(3))
            0: load_char(plain_char());
            1: send_item(FUNC_START, 8'($urandom_range(255)));
            2: send_item(FUNC_SUPPLY, 8'($urandom_range(255)));
            default: send_item(FUNC_RESUME, 8'($urandom_range(255)));
          endcase
        end
      end else begin
        load_snippet();
        drive_to_halt(80);
      end
    end
    idle_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_open_bracket_and_full_store();
    drive_to_halt(1000);
    load_text("[-][");
    send_item(FUNC_RESUME, 8'h00);
    while (prog_len < PROG_DEPTH - 1) begin
      case ($urandom_range(3))
        0: load_char(CH_PLUS);
        1: load_char(CH_MINUS);
        2: load_char(CH_GT);
        default: load_char(CH_LT);
      endcase
    end
    load_char(CH_NUL);
    load_char(CH_PLUS);
    load_char(CH_LF);
    load_char(CH_CR);
    load_char(8'hFF);
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_RESUME, 8'h00);
    send_item(FUNC_START, 8'h00);
    wait_drain();
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && result_valid) begin
      if (pending_events.size() == 0) begin
        $error("unexpected item: status %0d out_byte %0h", result.status, result.out_byte);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        if (result.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, result.status);
          err_count++;
        end
        if (result.out_byte !== want.out_byte) begin
          $error("out_byte mismatch: expected %0h actual %0h", want.out_byte,
                 result.out_byte);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    for (i = 0; i < TAPE_DEPTH; i++) tape_img[i] = 8'h00;
    for (i = 0; i < PROG_DEPTH; i++) prog_img[i] = 8'h00;
    prog_len = 0;
    head_pos = 0;
    instr_pc = 0;
    bracket_depth = 0;
    want_input = 1'b0;
    last_status = STAT_LOADED;
    last_had_event = 1'b0;
    items_sent = 0;
    err_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_start();
    test_directed_program();
    test_restart_clears_tape();
    test_random_sessions();
    test_open_bracket_and_full_store();

    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
